// File: src/nqp_pkg.sv
// ----------------------------------------------------------------------------
// nqp_pkg: shared types and constants of the normalized quaternion product
// Fixed widths of the datapath, status codes and a leading-one encoder.
// ----------------------------------------------------------------------------
package nqp_pkg;

	localparam int IN_FRAC_BITS  = 28;
	localparam int OUT_FRAC_BITS = 30;
	localparam int TOL_W         = 21;

	// normalized product datapath
	localparam int PM_W  = 30;                      // |component| after the right shift
	localparam int N_W   = 32;                      // rounded norm
	localparam int Q_W   = 31;                      // quotient, at most 2^30
	localparam int NUM_W = PM_W + OUT_FRAC_BITS + 1;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << OUT_FRAC_BITS;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_A_ZERO = 2'd1;
	localparam logic [1:0] ST_B_ZERO = 2'd2;

	typedef logic signed [31:0] comp_t;

	typedef struct packed {
		logic a_zero;
		logic b_zero;
	} zero_t;

	typedef struct packed {
		logic off_a;
		logic off_b;
	} off_t;

	// position of the highest set bit, 0 for a zero word
	function automatic logic [5:0] msb_pos(input logic [63:0] v);
		logic [63:0] x;
		logic [5:0]  pos;
		x   = v;
		pos = '0;
		if (x[63:32] != '0) begin
			pos[5] = 1'b1;
			x      = {32'd0, x[63:32]};
		end
		if (x[31:16] != '0) begin
			pos[4] = 1'b1;
			x      = {48'd0, x[31:16]};
		end
		if (x[15:8] != '0) begin
			pos[3] = 1'b1;
			x      = {56'd0, x[15:8]};
		end
		if (x[7:4] != '0) begin
			pos[2] = 1'b1;
			x      = {60'd0, x[7:4]};
		end
		if (x[3:2] != '0) begin
			pos[1] = 1'b1;
			x      = {62'd0, x[3:2]};
		end
		if (x[1]) begin
			pos[0] = 1'b1;
		end
		return pos;
	endfunction

endpackage

// File: src/normalized_quaternion_product_unit.sv
// ----------------------------------------------------------------------------
// normalized_quaternion_product_unit: unit-norm Hamilton product of two
// quaternions given in Q3.28, result in Q1.30 with non-negative scalar part.
// ----------------------------------------------------------------------------
// A new item is taken on every clock edge at which start is high; busy never
// rises, so items may follow one another in consecutive cycles without limit.
// Each item's result appears on done and the result ports for one cycle
// only, in the order taken. The receiver has no way to hold a result back:
// sample it in the cycle done is high. The chain runs through the input and
// magnitude stages, the four product lanes, the 31-bit rounded square root
// that forms the product's norm and the four 31-stage division lanes that
// scale each component to unit length. The input magnitudes for the
// renormalization flags run through their own 33-bit roots in parallel.
// status is ST_A_ZERO when the first input is all zero (every other field
// then reads zero), ST_B_ZERO when the second is (renorm_a is still valid).
// The tolerance tol_q is written through cfg_valid/cfg_data, which is always
// ready; write it only while no item is in flight. There is no state between
// items and no warm-up after reset.
// ----------------------------------------------------------------------------
module normalized_quaternion_product_unit
	import nqp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             start,
	output logic             busy,
	input  comp_t            a_x,
	input  comp_t            a_y,
	input  comp_t            a_z,
	input  comp_t            a_w,
	input  comp_t            b_x,
	input  comp_t            b_y,
	input  comp_t            b_z,
	input  comp_t            b_w,

	output logic             done,
	output comp_t            p_x,
	output comp_t            p_y,
	output comp_t            p_z,
	output logic [30:0]      p_w,
	output logic [1:0]       status,
	output logic             renorm_a,
	output logic             renorm_b,

	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TOL_W-1:0] cfg_data
);

	// pipeline depths and the stage at which each piece of the item lands
	localparam int MAG_SQ_W = 66;                  // 65-bit sum of squares, padded even
	localparam int N_SQ_W   = 62;                  // product sum of squares
	localparam int MAG_LAT  = MAG_SQ_W / 2 + 1;
	localparam int N_LAT    = N_SQ_W / 2 + 1;
	localparam int DIV_LAT  = Q_W + 2;
	localparam int ST_ZF    = 3;                   // zero flags known
	localparam int ST_MAG   = 5;                   // input sums of squares
	localparam int ST_OFF   = ST_MAG + MAG_LAT + 1;
	localparam int ST_PS    = 13;                  // product sum of squares
	localparam int ST_N     = ST_PS + N_LAT;       // norm ready, lanes start
	localparam int ST_OUT   = ST_N + DIV_LAT;      // result registers

	localparam logic [MAG_SQ_W/2:0] MAG_ONE = (MAG_SQ_W/2+1)'(1) << IN_FRAC_BITS;
	localparam comp_t PC_ONE = comp_t'({1'b0, Q_ONE});

	logic accept;
	logic [TOL_W-1:0] tol_q;

	// stage registers
	logic        v_s1;
	comp_t       a_s1 [4];
	comp_t       b_s1 [4];

	logic [31:0] ma_s2 [4];
	logic [31:0] mb_s2 [4];
	logic [3:0]  na_s2;
	logic [3:0]  nb_s2;

	logic [63:0] sqa_s3 [4];
	logic [63:0] sqb_s3 [4];
	logic [31:0] ma_s3 [4];
	logic [31:0] mb_s3 [4];
	logic [3:0]  na_s3;
	logic [3:0]  nb_s3;
	logic [1:0]  rsh_a_s3;
	logic [1:0]  rsh_b_s3;
	logic [4:0]  lsh_a_s3;
	logic [4:0]  lsh_b_s3;
	zero_t       zf_s3;

	logic [64:0] pa_s4 [2];
	logic [64:0] pb_s4 [2];
	comp_t       sa_s4 [4];
	comp_t       sb_s4 [4];

	logic [64:0] suma_s5;
	logic [64:0] sumb_s5;

	logic signed [63:0] p_s7 [4];

	logic [63:0] pm_s8 [4];
	logic [3:0]  pn_s8;

	logic [63:0]     pm_s9 [4];
	logic [3:0]      pn_s9;
	logic [5:0]      sh_s9;

	logic [PM_W-1:0] pm_s10 [4];
	logic [3:0]      cneg_s10;

	logic [2*PM_W-1:0] psq_s11 [4];
	logic [PM_W-1:0]   pm_s11 [4];
	logic [3:0]        cneg_s11;

	logic [2*PM_W:0]   pp_s12 [2];
	logic [PM_W-1:0]   pm_s12 [4];
	logic [3:0]        cneg_s12;

	logic [N_SQ_W-1:0] ps_s13;
	logic [3:0][PM_W:0] lane_s13;               // {flip, |component|} per lane

	logic [MAG_SQ_W/2:0] rt_a;
	logic [MAG_SQ_W/2:0] rt_b;
	off_t                off_s40;

	logic [N_W-1:0]      n_s45;
	logic [3:0][PM_W:0]  lane_s45;
	zero_t               zf_s45;
	logic                clr_s45;

	zero_t  zf_s77;
	off_t   off_s77;
	logic   v_s77;
	logic   v_s78;
	logic [1:0] status_s78;
	logic   renorm_a_s78;
	logic   renorm_b_s78;

	// combinational helpers
	logic [31:0] or_a;
	logic [31:0] or_b;
	logic [5:0]  msb_a;
	logic [5:0]  msb_b;
	logic [63:0] or_p;
	logic [5:0]  msb_p;
	logic [31:0] sva [4];
	logic [31:0] svb [4];
	logic        scalar_neg;

	comp_t [3:0] lx [4];
	comp_t [3:0] ly [4];
	logic  [3:0] lneg [4];
	comp_t       lres [4];

	assign accept    = start && !busy;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// block scaling: shift so the largest component sits in [2^29, 2^30)
	always_comb begin
		or_a = ma_s2[0] | ma_s2[1] | ma_s2[2] | ma_s2[3];
		or_b = mb_s2[0] | mb_s2[1] | mb_s2[2] | mb_s2[3];
		msb_a = msb_pos(64'(or_a));
		msb_b = msb_pos(64'(or_b));
		for (int i = 0; i < 4; i++) begin
			sva[i] = (rsh_a_s3 != '0) ? (ma_s3[i] >> rsh_a_s3) : (ma_s3[i] << lsh_a_s3);
			svb[i] = (rsh_b_s3 != '0) ? (mb_s3[i] >> rsh_b_s3) : (mb_s3[i] << lsh_b_s3);
		end
		or_p  = pm_s8[0] | pm_s8[1] | pm_s8[2] | pm_s8[3];
		msb_p = msb_pos(or_p);
		// a negative scalar part that truncates to zero counts as non-negative
		scalar_neg = pn_s9[3] && ((pm_s9[3] >> sh_s9) != '0);
	end

	always_ff @(posedge clk) begin
		// s1: take the item
		if (accept) begin
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			a_s1[3] <= a_w;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			b_s1[3] <= b_w;
		end

		// s2: magnitudes and signs
		for (int i = 0; i < 4; i++) begin
			ma_s2[i] <= a_s1[i][31] ? 32'(-a_s1[i]) : 32'(a_s1[i]);
			mb_s2[i] <= b_s1[i][31] ? 32'(-b_s1[i]) : 32'(b_s1[i]);
			na_s2[i] <= a_s1[i][31];
			nb_s2[i] <= b_s1[i][31];
		end

		// s3: squares, scaling shifts, zero detect
		for (int i = 0; i < 4; i++) begin
			sqa_s3[i] <= ma_s2[i] * ma_s2[i];
			sqb_s3[i] <= mb_s2[i] * mb_s2[i];
			ma_s3[i]  <= ma_s2[i];
			mb_s3[i]  <= mb_s2[i];
		end
		na_s3    <= na_s2;
		nb_s3    <= nb_s2;
		rsh_a_s3 <= or_a[31] ? 2'd2 : (or_a[30] ? 2'd1 : 2'd0);
		rsh_b_s3 <= or_b[31] ? 2'd2 : (or_b[30] ? 2'd1 : 2'd0);
		lsh_a_s3 <= 5'(6'd29 - msb_a);
		lsh_b_s3 <= 5'(6'd29 - msb_b);
		zf_s3.a_zero <= (or_a == '0);
		zf_s3.b_zero <= (or_b == '0);

		// s4: partial sums of squares, scaled components
		pa_s4[0] <= 65'(sqa_s3[0]) + 65'(sqa_s3[1]);
		pa_s4[1] <= 65'(sqa_s3[2]) + 65'(sqa_s3[3]);
		pb_s4[0] <= 65'(sqb_s3[0]) + 65'(sqb_s3[1]);
		pb_s4[1] <= 65'(sqb_s3[2]) + 65'(sqb_s3[3]);
		for (int i = 0; i < 4; i++) begin
			sa_s4[i] <= na_s3[i] ? comp_t'(-sva[i]) : comp_t'(sva[i]);
			sb_s4[i] <= nb_s3[i] ? comp_t'(-svb[i]) : comp_t'(svb[i]);
		end

		// s5: full sums of squares for the magnitude roots
		suma_s5 <= pa_s4[0] + pa_s4[1];
		sumb_s5 <= pb_s4[0] + pb_s4[1];

		// s8: product magnitudes and signs
		for (int i = 0; i < 4; i++) begin
			pm_s8[i] <= p_s7[i][63] ? 64'(-p_s7[i]) : 64'(p_s7[i]);
			pn_s8[i] <= p_s7[i][63];
		end

		// s9: right shift that brings every component below 2^30
		for (int i = 0; i < 4; i++) begin
			pm_s9[i] <= pm_s8[i];
		end
		pn_s9 <= pn_s8;
		sh_s9 <= (msb_p > 6'd29) ? (msb_p - 6'd29) : '0;

		// s10: drop the low bits, magnitude truncates toward zero; flip every
		// lane whose sign differs from the shifted scalar part
		for (int i = 0; i < 4; i++) begin
			pm_s10[i]   <= PM_W'(pm_s9[i] >> sh_s9);
			cneg_s10[i] <= pn_s9[i] ^ scalar_neg;
		end

		// s11..s13: sum of squares of the product
		for (int i = 0; i < 4; i++) begin
			psq_s11[i] <= pm_s10[i] * pm_s10[i];
			pm_s11[i]  <= pm_s10[i];
			pm_s12[i]  <= pm_s11[i];
		end
		cneg_s11  <= cneg_s10;
		cneg_s12  <= cneg_s11;
		pp_s12[0] <= (2*PM_W+1)'(psq_s11[0]) + (2*PM_W+1)'(psq_s11[1]);
		pp_s12[1] <= (2*PM_W+1)'(psq_s11[2]) + (2*PM_W+1)'(psq_s11[3]);
		ps_s13    <= N_SQ_W'(pp_s12[0]) + N_SQ_W'(pp_s12[1]);
		for (int i = 0; i < 4; i++) begin
			lane_s13[i] <= {cneg_s12[i], pm_s12[i]};
		end

		// s40: distance of each input magnitude from one
		off_s40.off_a <= ((rt_a >= MAG_ONE) ? (rt_a - MAG_ONE) : (MAG_ONE - rt_a))
			> (MAG_SQ_W/2+1)'(tol_q);
		off_s40.off_b <= ((rt_b >= MAG_ONE) ? (rt_b - MAG_ONE) : (MAG_ONE - rt_b))
			> (MAG_SQ_W/2+1)'(tol_q);

		// s78: status and flags line up with the lane results
		if (zf_s77.a_zero) begin
			status_s78 <= ST_A_ZERO;
		end else if (zf_s77.b_zero) begin
			status_s78 <= ST_B_ZERO;
		end else begin
			status_s78 <= ST_OK;
		end
		renorm_a_s78 <= !zf_s77.a_zero && off_s77.off_a;
		renorm_b_s78 <= !zf_s77.a_zero && !zf_s77.b_zero && off_s77.off_b;
	end

	// input magnitude roots
	nqp_sqrt #(.W(MAG_SQ_W)) u_sqrt_a (
		.clk  (clk),
		.rad  ({1'b0, suma_s5}),
		.root (rt_a)
	);

	nqp_sqrt #(.W(MAG_SQ_W)) u_sqrt_b (
		.clk  (clk),
		.rad  ({1'b0, sumb_s5}),
		.root (rt_b)
	);

	// Hamilton product lanes; lane 3 is the scalar part
	always_comb begin
		lx[0][0] = sa_s4[3]; ly[0][0] = sb_s4[0];
		lx[0][1] = sa_s4[0]; ly[0][1] = sb_s4[3];
		lx[0][2] = sa_s4[1]; ly[0][2] = sb_s4[2];
		lx[0][3] = sa_s4[2]; ly[0][3] = sb_s4[1];
		lneg[0]  = 4'b1000;

		lx[1][0] = sa_s4[3]; ly[1][0] = sb_s4[1];
		lx[1][1] = sa_s4[1]; ly[1][1] = sb_s4[3];
		lx[1][2] = sa_s4[2]; ly[1][2] = sb_s4[0];
		lx[1][3] = sa_s4[0]; ly[1][3] = sb_s4[2];
		lneg[1]  = 4'b1000;

		lx[2][0] = sa_s4[3]; ly[2][0] = sb_s4[2];
		lx[2][1] = sa_s4[2]; ly[2][1] = sb_s4[3];
		lx[2][2] = sa_s4[0]; ly[2][2] = sb_s4[1];
		lx[2][3] = sa_s4[1]; ly[2][3] = sb_s4[0];
		lneg[2]  = 4'b1000;

		lx[3][0] = sa_s4[3]; ly[3][0] = sb_s4[3];
		lx[3][1] = sa_s4[0]; ly[3][1] = sb_s4[0];
		lx[3][2] = sa_s4[1]; ly[3][2] = sb_s4[1];
		lx[3][3] = sa_s4[2]; ly[3][3] = sb_s4[2];
		lneg[3]  = 4'b1110;
	end

	for (genvar l = 0; l < 4; l++) begin : g_prod
		nqp_prod_lane u_prod (
			.clk (clk),
			.x   (lx[l]),
			.y   (ly[l]),
			.neg (lneg[l]),
			.p   (p_s7[l])
		);
	end

	// product norm
	nqp_sqrt #(.W(N_SQ_W)) u_sqrt_n (
		.clk  (clk),
		.rad  (ps_s13),
		.root (n_s45)
	);

	// hold lane magnitudes and signs while the norm is formed
	nqp_delay #(.W(4 * (PM_W + 1)), .D(ST_N - ST_PS)) u_dly_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (lane_s13),
		.dout   (lane_s45)
	);

	nqp_delay #(.W($bits(zero_t)), .D(ST_N - ST_ZF)) u_dly_zf_n (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (zf_s3),
		.dout   (zf_s45)
	);

	// a zero input or a zero norm drops every component to zero
	assign clr_s45 = zf_s45.a_zero || zf_s45.b_zero || (n_s45 == '0);

	for (genvar l = 0; l < 4; l++) begin : g_div
		nqp_div_lane u_div (
			.clk  (clk),
			.mag  (lane_s45[l][PM_W-1:0]),
			.den  (n_s45),
			.flip (lane_s45[l][PM_W]),
			.clr  (clr_s45),
			.res  (lres[l])
		);
	end

	nqp_delay #(.W($bits(zero_t)), .D(ST_OUT - 1 - ST_N)) u_dly_zf_out (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (zf_s45),
		.dout   (zf_s77)
	);

	nqp_delay #(.W($bits(off_t)), .D(ST_OUT - 1 - ST_OFF)) u_dly_off (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (off_s40),
		.dout   (off_s77)
	);

	nqp_delay #(.W(1), .D(ST_OUT - 2)) u_dly_valid (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (v_s1),
		.dout   (v_s77)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s78 <= 1'b0;
		end else begin
			v_s78 <= v_s77;
		end
	end

	assign done     = v_s78;
	assign p_x      = lres[0];
	assign p_y      = lres[1];
	assign p_z      = lres[2];
	assign p_w      = lres[3][30:0];
	assign status   = status_s78;
	assign renorm_a = renorm_a_s78;
	assign renorm_b = renorm_b_s78;

	// a rejected item carries an all-zero product
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> p_x == '0 && p_y == '0 && p_z == '0 && p_w == '0)
		else $error("nonzero product on a zero input");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_A_ZERO |-> !renorm_a && !renorm_b)
		else $error("renorm flag raised with first input zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> p_w <= Q_ONE)
		else $error("scalar part above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> p_x <= PC_ONE && p_x >= -PC_ONE && p_y <= PC_ONE && p_y >= -PC_ONE
			&& p_z <= PC_ONE && p_z >= -PC_ONE)
		else $error("vector component outside unit range");

endmodule

// File: src/nqp_delay.sv
// ----------------------------------------------------------------------------
// nqp_delay: fixed-length delay line
// Carries side information alongside the long arithmetic pipelines.
// ----------------------------------------------------------------------------
module nqp_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				line_q[i] <= '0;
			end
		end else begin
			line_q[0] <= din;
			for (int i = 1; i < D; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[D-1];

endmodule

// File: src/nqp_sqrt.sv
// ----------------------------------------------------------------------------
// nqp_sqrt: pipelined square root, rounded half up
// One root bit per stage, then a rounding stage.
// ----------------------------------------------------------------------------
module nqp_sqrt #(
	parameter int W = 66
) (
	input  logic         clk,
	input  logic [W-1:0] rad,
	output logic [W/2:0] root
);

	localparam int R  = W / 2;
	localparam int RW = R + 2;

	logic [RW-1:0] rem_s  [R];
	logic [R-1:0]  root_s [R];
	logic [W-1:0]  x_s    [R-1];

	for (genvar i = 0; i < R; i++) begin : g_step
		logic [RW-1:0] rem_in;
		logic [R-1:0]  root_in;
		logic [W-1:0]  x_in;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = rad;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign x_in    = x_s[i-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_in[R-1:0], x_in[W-1 -: 2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				rem_s[i]  <= cur - trial;
				root_s[i] <= {root_in[R-2:0], 1'b1};
			end else begin
				rem_s[i]  <= cur;
				root_s[i] <= {root_in[R-2:0], 1'b0};
			end
		end

		if (i < R - 1) begin : g_shift
			always_ff @(posedge clk) begin
				x_s[i] <= x_in << 2;
			end
		end
	end

	// remainder above the floor root means the exact root is past one half
	always_ff @(posedge clk) begin
		root <= {1'b0, root_s[R-1]} + (R+1)'(rem_s[R-1] > {2'b00, root_s[R-1]});
	end

endmodule

// File: src/nqp_prod_lane.sv
// ----------------------------------------------------------------------------
// nqp_prod_lane: one component of the Hamilton product
// Four signed products, then a registered two-level sum with per-term signs.
// ----------------------------------------------------------------------------
module nqp_prod_lane
	import nqp_pkg::*;
(
	input  logic               clk,
	input  comp_t [3:0]        x,
	input  comp_t [3:0]        y,
	input  logic  [3:0]        neg,
	output logic signed [63:0] p
);

	logic signed [63:0] prod_s1 [4];
	logic signed [63:0] term    [4];
	logic signed [63:0] pair_s2 [2];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			term[j] = neg[j] ? -prod_s1[j] : prod_s1[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			prod_s1[j] <= $signed(x[j]) * $signed(y[j]);
		end
		pair_s2[0] <= term[0] + term[1];
		pair_s2[1] <= term[2] + term[3];
		p          <= pair_s2[0] + pair_s2[1];
	end

endmodule

// File: src/nqp_div_lane.sv
// ----------------------------------------------------------------------------
// nqp_div_lane: scale one product component to unit norm
// Rounded restoring division, one quotient bit per stage, then sign and clamp.
// ----------------------------------------------------------------------------
module nqp_div_lane
	import nqp_pkg::*;
(
	input  logic            clk,
	input  logic [PM_W-1:0] mag,
	input  logic [N_W-1:0]  den,
	input  logic            flip,
	input  logic            clr,
	output comp_t           res
);

	logic [NUM_W-1:0] num_s0;
	logic [N_W-1:0]   den_s0;
	logic             flip_s0;
	logic             clr_s0;

	logic [N_W-1:0] rem_s  [Q_W-1];
	logic [Q_W-1:0] lo_s   [Q_W-1];
	logic [N_W-1:0] dd_s   [Q_W-1];
	logic [Q_W-1:0] quo_s  [Q_W];
	logic           flip_s [Q_W];
	logic           clr_s  [Q_W];

	logic [Q_W-1:0] qsat;
	logic [31:0]    qx;

	// numerator carries half the divisor so the quotient rounds half up
	always_ff @(posedge clk) begin
		num_s0  <= NUM_W'({mag, {OUT_FRAC_BITS{1'b0}}}) + NUM_W'(den >> 1);
		den_s0  <= den;
		flip_s0 <= flip;
		clr_s0  <= clr;
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [N_W-1:0] rem_in;
		logic [Q_W-1:0] lo_in;
		logic [N_W-1:0] den_in;
		logic [Q_W-1:0] quo_in;
		logic           flip_in;
		logic           clr_in;
		logic [N_W:0]   cur;
		logic [N_W:0]   diff;
		logic           ge;

		if (j == 0) begin : g_first
			assign rem_in  = N_W'(num_s0[NUM_W-1:Q_W]);
			assign lo_in   = num_s0[Q_W-1:0];
			assign den_in  = den_s0;
			assign quo_in  = '0;
			assign flip_in = flip_s0;
			assign clr_in  = clr_s0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign lo_in   = lo_s[j-1];
			assign den_in  = dd_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign flip_in = flip_s[j-1];
			assign clr_in  = clr_s[j-1];
		end

		assign cur  = {rem_in, lo_in[Q_W-1]};
		assign ge   = cur >= {1'b0, den_in};
		assign diff = cur - {1'b0, den_in};

		always_ff @(posedge clk) begin
			quo_s[j]  <= {quo_in[Q_W-2:0], ge};
			flip_s[j] <= flip_in;
			clr_s[j]  <= clr_in;
		end

		if (j < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j] <= ge ? diff[N_W-1:0] : cur[N_W-1:0];
				lo_s[j]  <= lo_in << 1;
				dd_s[j]  <= den_in;
			end
		end
	end

	assign qsat = (quo_s[Q_W-1] > Q_ONE) ? Q_ONE : quo_s[Q_W-1];
	assign qx   = {1'b0, qsat};

	always_ff @(posedge clk) begin
		if (clr_s[Q_W-1]) begin
			res <= '0;
		end else if (flip_s[Q_W-1]) begin
			res <= comp_t'(-qx);
		end else begin
			res <= comp_t'(qx);
		end
	end

endmodule

// File: tb/sv/nqp_product_checker.sv
// ----------------------------------------------------------------------------
// nqp_product_checker: scoreboard of the normalized quaternion product unit
// Watches the item, result and tolerance channels, predicts each result from
// the accepted item and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module nqp_product_checker
	import nqp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  comp_t            a_x,
	input  comp_t            a_y,
	input  comp_t            a_z,
	input  comp_t            a_w,
	input  comp_t            b_x,
	input  comp_t            b_y,
	input  comp_t            b_z,
	input  comp_t            b_w,
	input  logic             done,
	input  comp_t            p_x,
	input  comp_t            p_y,
	input  comp_t            p_z,
	input  logic [30:0]      p_w,
	input  logic [1:0]       status,
	input  logic             renorm_a,
	input  logic             renorm_b,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [TOL_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;

	typedef struct {
		comp_t       x;
		comp_t       y;
		comp_t       z;
		logic [30:0] w;
		logic [1:0]  st;
		logic        ra;
		logic        rb;
	} product_t;

	product_t          pending_products[$];
	logic [TOL_W-1:0]  tolerance;

	function automatic u64_t abs64(longint v);
		return v < 0 ? u64_t'(0) - u64_t'(v) : u64_t'(v);
	endfunction

	function automatic u64_t root_floor(u64_t s);
		u64_t r;
		u64_t bit_w;
		r     = 0;
		bit_w = u64_t'(1) << 62;
		while (bit_w > s)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (s >= r + bit_w) begin
				s = s - (r + bit_w);
				r = (r >> 1) + bit_w;
			end else begin
				r >>= 1;
			end
			bit_w >>= 2;
		end
		return r;
	endfunction

	function automatic u64_t root_round(u64_t s);
		u64_t r;
		r = root_floor(s);
		if (s - r * r > r)
			r++;
		return r;
	endfunction

	function automatic longint trunc_shift(longint v, int sh);
		u64_t m;
		m = abs64(v) >> sh;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// rounded magnitude; all-zero reported separately
	function automatic u64_t quat_magnitude(longint q[4], output logic is_zero);
		logic [65:0] s;
		s = '0;
		for (int i = 0; i < 4; i++)
			s += 66'(abs64(q[i]) * abs64(q[i]));
		is_zero = (s == 0);
		if (s[64])
			return u64_t'(1) << 32;
		return root_round(u64_t'(s[63:0]));
	endfunction

	function automatic logic off_unit(u64_t mg, logic [TOL_W-1:0] tol);
		u64_t one;
		u64_t d;
		one = u64_t'(1) << IN_FRAC_BITS;
		d   = mg > one ? mg - one : one - mg;
		return d > u64_t'(tol);
	endfunction

	function automatic void block_scale(longint q[4], output longint o[4]);
		u64_t m;
		int   k;
		int   r;
		m = 0;
		k = 0;
		r = 0;
		for (int i = 0; i < 4; i++)
			if (abs64(q[i]) > m)
				m = abs64(q[i]);
		if (m >= (u64_t'(1) << 30))
			r = (m >= (u64_t'(1) << 31)) ? 2 : 1;
		else
			while (k < 30 && (m << k) < (u64_t'(1) << 29))
				k++;
		for (int i = 0; i < 4; i++)
			o[i] = r != 0 ? trunc_shift(q[i], r) : q[i] * (longint'(1) << k);
	endfunction

	// index 0..2 vector part, 3 scalar part
	function automatic product_t unit_product(longint a[4], longint b[4],
			logic [TOL_W-1:0] tol);
		product_t res;
		longint   sa[4];
		longint   sb[4];
		longint   p[4];
		logic     za;
		logic     zb;
		u64_t     mg;
		u64_t     m;
		u64_t     s;
		u64_t     n;
		u64_t     q;
		int       sh;
		logic     neg;
		logic     cneg;
		logic [31:0] comp[4];
		res = '{x: '0, y: '0, z: '0, w: '0, st: ST_OK, ra: 1'b0, rb: 1'b0};
		mg = quat_magnitude(a, za);
		if (za) begin
			res.st = ST_A_ZERO;
			return res;
		end
		res.ra = off_unit(mg, tol);
		mg = quat_magnitude(b, zb);
		if (zb) begin
			res.st = ST_B_ZERO;
			return res;
		end
		res.rb = off_unit(mg, tol);
		block_scale(a, sa);
		block_scale(b, sb);
		p[3] = sa[3] * sb[3] - (sa[0] * sb[0] + sa[1] * sb[1] + sa[2] * sb[2]);
		p[0] = sa[3] * sb[0] + sb[3] * sa[0] + (sa[1] * sb[2] - sa[2] * sb[1]);
		p[1] = sa[3] * sb[1] + sb[3] * sa[1] + (sa[2] * sb[0] - sa[0] * sb[2]);
		p[2] = sa[3] * sb[2] + sb[3] * sa[2] + (sa[0] * sb[1] - sa[1] * sb[0]);
		m = 0;
		for (int i = 0; i < 4; i++)
			if (abs64(p[i]) > m)
				m = abs64(p[i]);
		sh = 0;
		while (sh < 63 && (m >> sh) >= (u64_t'(1) << 30))
			sh++;
		s = 0;
		for (int i = 0; i < 4; i++) begin
			p[i] = trunc_shift(p[i], sh);
			s += abs64(p[i]) * abs64(p[i]);
		end
		n = root_round(s);
		if (n == 0)
			return res;
		neg = p[3] < 0;
		for (int i = 0; i < 4; i++) begin
			q    = ((abs64(p[i]) << 30) + (n >> 1)) / n;
			cneg = (p[i] < 0) != neg;
			if (q > u64_t'(Q_ONE))
				q = u64_t'(Q_ONE);
			comp[i] = cneg ? 32'(u64_t'(0) - q) : 32'(q);
		end
		res.x = comp_t'(comp[0]);
		res.y = comp_t'(comp[1]);
		res.z = comp_t'(comp[2]);
		res.w = comp[3][30:0];
		return res;
	endfunction

	assign pending_count = pending_products.size();

	always @(posedge clk or negedge arst_n) begin
		product_t exp_p;
		longint   qa[4];
		longint   qb[4];
		if (!arst_n) begin
			tolerance  <= '0;
			fail_count <= 0;
			pending_products.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				tolerance <= cfg_data;
			// predict with the tolerance in force before this edge
			if (start && !busy) begin
				qa = '{a_x, a_y, a_z, a_w};
				qb = '{b_x, b_y, b_z, b_w};
				pending_products = {pending_products, unit_product(qa, qb, tolerance)};
			end
			if (done) begin
				if (pending_products.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d st=%0d",
						$time, p_x, p_y, p_z, p_w, status);
					fail_count <= fail_count + 1;
				end else begin
					exp_p = pending_products.pop_front();
					if (exp_p.x !== p_x || exp_p.y !== p_y || exp_p.z !== p_z ||
							exp_p.w !== p_w || exp_p.st !== status ||
							exp_p.ra !== renorm_a || exp_p.rb !== renorm_b) begin
						$display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d st=%0d ra=%0b rb=%0b",
							$time, exp_p.x, exp_p.y, exp_p.z, exp_p.w, exp_p.st,
							exp_p.ra, exp_p.rb);
						$display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d st=%0d ra=%0b rb=%0b",
							$time, p_x, p_y, p_z, p_w, status, renorm_a, renorm_b);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_normalized_quaternion_product_unit.sv
// ----------------------------------------------------------------------------
// tb_normalized_quaternion_product_unit: stimulus and verdict
// Drives quaternion pairs through the unit in random bursts under several
// tolerance settings; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb_normalized_quaternion_product_unit;
	import nqp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 78;
	localparam int RANDOM_ITEMS = 200;   // per tolerance phase, four phases

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	comp_t            a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
	logic             done;
	comp_t            p_x, p_y, p_z;
	logic [30:0]      p_w;
	logic [1:0]       status;
	logic             renorm_a, renorm_b;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [TOL_W-1:0] cfg_data;
	int               fail_count;
	int               pending_count;
	int               burst_left;

	normalized_quaternion_product_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.done(done), .p_x(p_x), .p_y(p_y), .p_z(p_z), .p_w(p_w),
		.status(status), .renorm_a(renorm_a), .renorm_b(renorm_b),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	nqp_product_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.done(done), .p_x(p_x), .p_y(p_y), .p_z(p_z), .p_w(p_w),
		.status(status), .renorm_a(renorm_a), .renorm_b(renorm_b),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Present one item at the falling edge and hold it until taken.
	// start stays high on return; the caller drops it for a gap.
	task automatic send_pair(comp_t ax, comp_t ay, comp_t az, comp_t aw,
			comp_t bx, comp_t by, comp_t bz, comp_t bw);
		a_x = ax; a_y = ay; a_z = az; a_w = aw;
		b_x = bx; b_y = by; b_z = bz; b_w = bw;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Send with burst pacing: inside a burst the next item follows at once,
	// between bursts start drops for a random gap.
	task automatic paced_pair(comp_t ax, comp_t ay, comp_t az, comp_t aw,
			comp_t bx, comp_t by, comp_t bz, comp_t bw);
		int gap;
		send_pair(ax, ay, az, aw, bx, by, bz, bw);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			start = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Write the tolerance once the pipe has drained.
	task automatic set_tolerance(logic [TOL_W-1:0] tol);
		start = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_data  = tol;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Draw a component: a unit basis value, one half or a smaller random value, plus noise.
	function automatic comp_t unitish(int idx, int hot, int mode, int noise);
		comp_t base;
		int    n;
		n = $urandom_range(0, 2 * noise) - noise;
		case (mode)
			0: base = (idx == hot) ? comp_t'(1 << IN_FRAC_BITS) : '0;
			1: base = comp_t'(1 << (IN_FRAC_BITS - 1));
			default: base = comp_t'($urandom_range(0, 1 << (IN_FRAC_BITS - 1)));
		endcase
		if ($urandom_range(0, 1))
			base = -base;
		return base + comp_t'(n);
	endfunction

	task automatic random_pair();
		comp_t q[8];
		int    sel;
		int    hot;
		int    mode;
		int    noise;
		int    sh;
		sel = $urandom_range(0, 9);
		for (int h = 0; h < 2; h++) begin
			hot   = $urandom_range(0, 3);
			mode  = $urandom_range(0, 2);
			noise = $urandom_range(0, 3) == 0 ? 1 << $urandom_range(0, 22) : 64;
			sh    = $urandom_range(0, 31);
			for (int i = 0; i < 4; i++) begin
				if (sel < 6)
					q[h * 4 + i] = unitish(i, hot, mode, noise);
				else if (sel < 8)
					q[h * 4 + i] = comp_t'($urandom);
				else
					q[h * 4 + i] = comp_t'($urandom) >>> sh;
			end
		end
		// occasionally zero out one side to hit the status paths
		if ($urandom_range(0, 29) == 0)
			for (int i = 0; i < 4; i++) q[i] = '0;
		else if ($urandom_range(0, 29) == 0)
			for (int i = 4; i < 8; i++) q[i] = '0;
		paced_pair(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
	endtask

	task automatic directed_pairs();
		comp_t one, half, mx, mn;
		one  = comp_t'(1 << IN_FRAC_BITS);
		half = comp_t'(1 << (IN_FRAC_BITS - 1));
		mx   = comp_t'(32'h7fff_ffff);
		mn   = comp_t'(32'h8000_0000);
		// first zero: second not examined; second zero; both zero
		paced_pair(0, 0, 0, 0, 0, 0, 0, one);
		paced_pair(0, 0, 0, one, 0, 0, 0, 0);
		paced_pair(0, 0, 0, 0, 0, 0, 0, 0);
		paced_pair(mx, 0, 0, 0, 0, 0, 0, 0);
		// identity times identity, basis products, negative scalar result
		paced_pair(0, 0, 0, one, 0, 0, 0, one);
		paced_pair(one, 0, 0, 0, 0, one, 0, 0);
		paced_pair(one, 0, 0, 0, one, 0, 0, 0);
		paced_pair(0, 0, 0, -one, 0, 0, 0, one);
		paced_pair(half, half, half, half, -half, half, -half, half);
		// scalar part exactly zero
		paced_pair(0, 0, one, 0, 0, 0, 0, one);
		// magnitude extremes: most negative, most positive, mixed, then single LSBs
		paced_pair(mn, mn, mn, mn, mn, mn, mn, mn);
		paced_pair(mx, mx, mx, mx, mx, mx, mx, mx);
		paced_pair(mx, mn, mx, mn, mn, mx, mn, mx);
		paced_pair(1, 0, 0, 0, 0, 0, 0, -1);
		paced_pair(-1, -1, -1, -1, 1, 1, 1, 1);
		// one LSB either side of unit magnitude, and a large offset
		paced_pair(0, 0, 0, one + 1, 0, 0, 0, one - 1);
		paced_pair(0, 0, 0, one + 1048576, 0, 0, 0, one - 1048577);
		paced_pair(0, 0, 0, mx, 0, 0, 0, mn);
	endtask

	initial begin
		logic [TOL_W-1:0] tol_steps[4];
		arst_n     = 1'b0;
		start      = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		burst_left = 0;
		{a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset tolerance first, then 2^20, a small random value and the full
		// register width
		tol_steps = '{0, 1048576, TOL_W'($urandom_range(1, 4096)), {TOL_W{1'b1}}};
		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0)
				set_tolerance(tol_steps[ph]);
			if (ph < 2)
				directed_pairs();
			for (int n = 0; n < RANDOM_ITEMS; n++)
				random_pair();
		end
		start = 1'b0;

		// drain, then give any stray result time to show up
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
